// ----- design/triangle_height_scale_core_defines.svh -----
// Assertion macros shared by the triangle height scale design.
`ifndef TRIANGLE_HEIGHT_SCALE_CORE_DEFINES_SVH
`define TRIANGLE_HEIGHT_SCALE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define THS_ASSERT_IMPLY(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk and disabled during rst.
`define THS_ASSERT_NEXT(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("assertion failed");

`endif

// ----- design/ths_pkg.sv -----
// Package with widths, codes, types and helpers of the triangle height scale core.
package ths_pkg;

  localparam int CW   = 32;
  localparam int FB   = 16;
  localparam int RW   = 31;
  localparam int NAX  = 3;
  localparam int IDXW = 3;
  localparam int DW   = CW + 1;
  localparam int NW   = DW;
  localparam int PW   = 2 * CW;
  localparam int DOTW = PW + 2;
  localparam int NUMW = 3 * CW;
  localparam int QW   = CW + 1;
  localparam int MW   = QW + 1;
  localparam int PSW  = MW + 1;
  localparam int QSW  = QW + 3;
  localparam int SPW  = CW + QSW;
  localparam int SQW  = CW;
  localparam int SQS  = SQW;
  localparam int SRW  = CW + 2;
  localparam int HW   = CW + 1;
  localparam int HSW  = CW + HW + 1;
  localparam int SATW = 2 * CW + 4;

  localparam logic [RW-1:0] LEN_RESET = RW'(32'h4000_0000);
  localparam logic [RW-1:0] RCP_RESET = RW'(4);

  localparam logic signed [SATW-1:0] SAT_HI = SATW'({1'b0, {(CW-1){1'b1}}});
  localparam logic signed [SATW-1:0] SAT_LO = -SAT_HI - SATW'(1);
  localparam logic signed [SATW-1:0] HALF_F = SATW'(1) <<< (FB - 1);
  localparam logic signed [PW-1:0]   HALF_W = PW'(1) <<< (2 * FB - 1);

  typedef logic signed [CW-1:0] coord_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ZERO_BASE = 2'd1,
    ST_ON_LINE   = 2'd2
  } status_t;

  typedef enum logic [IDXW-1:0] {
    REG_LEN_X = 3'd0,
    REG_LEN_Y = 3'd1,
    REG_LEN_Z = 3'd2,
    REG_RCP_X = 3'd3,
    REG_RCP_Y = 3'd4,
    REG_RCP_Z = 3'd5
  } reg_idx_t;

  typedef struct packed {
    coord_t [NAX-1:0] r0;
    coord_t [NAX-1:0] r1;
    coord_t           s;
  } pts_t;

  typedef struct packed {
    coord_t [NAX-1:0] r0;
    coord_t [NAX-1:0] r1;
    coord_t [NAX-1:0] a;
    coord_t           s;
    status_t          st;
    logic [PW-1:0]    bb;
    logic [NAX-1:0]   neg;
  } div_carry_t;

  typedef struct packed {
    coord_t [NAX-1:0] apex;
    coord_t           s;
    status_t          st;
  } sq_carry_t;

  function automatic coord_t sat_coord(input logic signed [SATW-1:0] x);
    coord_t r;
    if (x > SAT_HI) begin
      r = coord_t'(SAT_HI[CW-1:0]);
    end else if (x < SAT_LO) begin
      r = coord_t'(SAT_LO[CW-1:0]);
    end else begin
      r = coord_t'(x[CW-1:0]);
    end
    return r;
  endfunction

endpackage

// ----- design/triangle_height_scale_core.sv -----
// Top level of the triangle height scale core: wrap, projection, division, root, scaling.
//
//   Channel   Handshake               Carries
//   input     start, busy             r0, r1, r2 and height scale
//   config    cfg_valid, cfg_ready    register index and write data
//   result    done                    moved apex, scaled height, status
//
// One transaction is accepted every cycle; busy is always low.
// The result passes through the 33-step long division of the projection
// and the 32-step square root, each one stage per step.
// Synchronous reset clears all valid bits and loads the default box registers.
// The receiver cannot stall, so the pipeline never holds.
`include "triangle_height_scale_core_defines.svh"

module triangle_height_scale_core
  import ths_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  coord_t          base_start_x,
  input  coord_t          base_start_y,
  input  coord_t          base_start_z,
  input  coord_t          apex_x,
  input  coord_t          apex_y,
  input  coord_t          apex_z,
  input  coord_t          base_end_x,
  input  coord_t          base_end_y,
  input  coord_t          base_end_z,
  input  coord_t          height_scale,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [IDXW-1:0] cfg_index,
  input  logic [RW-1:0]   cfg_data,
  output logic            done,
  output coord_t          new_apex_x,
  output coord_t          new_apex_y,
  output coord_t          new_apex_z,
  output coord_t          scaled_height,
  output logic [1:0]      status
);

  logic [RW-1:0] box_len [NAX];
  logic [RW-1:0] box_recip [NAX];

  logic accept;
  coord_t in_r0 [NAX];
  coord_t in_r1 [NAX];
  coord_t in_r2 [NAX];

  logic s1_valid, s2_valid, s3_valid, s4_valid, s5_valid, s6_valid, s7_valid;
  pts_t s1_p, s2_p, s3_p, s4_p, s5_p, s6_p, s7_p;
  logic signed [DW-1:0] s1_d [NAX];
  logic signed [DW-1:0] s1_e [NAX];
  logic signed [DW-1:0] s2_d [NAX];
  logic signed [DW-1:0] s2_e [NAX];
  logic signed [PW-1:0] s2_td [NAX];
  logic signed [PW-1:0] s2_te [NAX];
  logic signed [NW-1:0] s2_nd [NAX];
  logic signed [NW-1:0] s2_ne [NAX];
  logic signed [DW-1:0] s3_d [NAX];
  logic signed [DW-1:0] s3_e [NAX];
  logic signed [PW-1:0] s3_pd [NAX];
  logic signed [PW-1:0] s3_pe [NAX];
  coord_t s4_a [NAX];
  coord_t s4_b [NAX];
  coord_t s5_a [NAX];
  coord_t s5_b [NAX];
  logic signed [PW-1:0] s5_xa [NAX];
  logic signed [PW-1:0] s5_xb [NAX];
  logic signed [PW-1:0] s5_ab [NAX];
  logic signed [PW-1:0] s5_bq [NAX];
  logic s5_bzero;
  coord_t s6_a [NAX];
  coord_t s6_b [NAX];
  logic signed [DOTW-1:0] s6_dot;
  logic [PW-1:0] s6_bb;
  status_t s6_st;
  logic [DOTW-1:0] s6_abs;
  logic [CW-1:0] s6_m [NAX];
  coord_t s7_a [NAX];
  logic [PW-1:0] s7_lo [NAX];
  logic [PW-1:0] s7_hp [NAX];
  logic [PW-1:0] s7_bb;
  logic [NAX-1:0] s7_neg;
  status_t s7_st;

  div_carry_t c8;
  logic [NUMW-1:0] num8 [NAX];

  logic [QW:0] dv_valid;
  logic [PW-1:0] dv_rem [QW+1][NAX];
  logic [QW-1:0] dv_qn [QW+1][NAX];
  div_carry_t dv_c [QW+1];
  logic [PW-1:0] dn_rem [QW][NAX];
  logic [QW-1:0] dn_qn [QW][NAX];

  logic [MW-1:0] r_mag [NAX];
  logic signed [PSW-1:0] r_pv [NAX];
  logic r_valid;
  logic signed [QSW-1:0] r_q [NAX];
  logic signed [QSW-1:0] r_base [NAX];
  div_carry_t r_c;

  logic [QSW-1:0] q_abs [NAX];
  logic q_valid;
  logic [PW-1:0] q_sq [NAX];
  logic signed [SPW-1:0] q_sp [NAX];
  logic signed [QSW-1:0] q_base [NAX];
  div_carry_t q_c;

  logic [PW+1:0] a_sum;
  logic [PW-1:0] a_qq;
  sq_carry_t a_c;

  logic [SQS:0] sq_valid;
  logic [SRW-1:0] sq_rem [SQS+1];
  logic [SQW-1:0] sq_root [SQS+1];
  logic [PW-1:0] sq_x [SQS+1];
  sq_carry_t sq_c [SQS+1];
  logic [SRW-1:0] sn_rem [SQS];
  logic [SQW-1:0] sn_root [SQS];

  logic [HW-1:0] h_root;
  logic h_valid;
  logic signed [HSW-1:0] h_prod;
  sq_carry_t h_c;
  status_t out_st;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign status    = out_st;

  assign in_r0[0] = base_start_x;
  assign in_r0[1] = base_start_y;
  assign in_r0[2] = base_start_z;
  assign in_r1[0] = apex_x;
  assign in_r1[1] = apex_y;
  assign in_r1[2] = apex_z;
  assign in_r2[0] = base_end_x;
  assign in_r2[1] = base_end_y;
  assign in_r2[2] = base_end_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NAX; i++) begin
        box_len[i]   <= LEN_RESET;
        box_recip[i] <= RCP_RESET;
      end
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_LEN_X: box_len[0] <= cfg_data;
        REG_LEN_Y: box_len[1] <= cfg_data;
        REG_LEN_Z: box_len[2] <= cfg_data;
        REG_RCP_X: box_recip[0] <= cfg_data;
        REG_RCP_Y: box_recip[1] <= cfg_data;
        REG_RCP_Z: box_recip[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      s6_valid <= 1'b0;
      s7_valid <= 1'b0;
      dv_valid <= '0;
      r_valid  <= 1'b0;
      q_valid  <= 1'b0;
      sq_valid <= '0;
      h_valid  <= 1'b0;
      done     <= 1'b0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
      s6_valid <= s5_valid;
      s7_valid <= s6_valid;
      dv_valid <= {dv_valid[QW-1:0], s7_valid};
      r_valid  <= dv_valid[QW];
      q_valid  <= r_valid;
      sq_valid <= {sq_valid[SQS-1:0], q_valid};
      h_valid  <= sq_valid[SQS];
      done     <= h_valid;
    end
  end

  always_comb begin
    logic signed [PW-1:0] td;
    logic signed [PW-1:0] te;
    for (int i = 0; i < NAX; i++) begin
      td = s2_td[i] + HALF_W;
      te = s2_te[i] + HALF_W;
      s2_nd[i] = NW'(td >>> (2 * FB));
      s2_ne[i] = NW'(te >>> (2 * FB));
    end
  end

  always_ff @(posedge clk) begin
    s1_p.s <= height_scale;
    for (int i = 0; i < NAX; i++) begin
      s1_p.r0[i] <= in_r0[i];
      s1_p.r1[i] <= in_r1[i];
      s1_d[i] <= DW'(in_r1[i]) - DW'(in_r0[i]);
      s1_e[i] <= DW'(in_r2[i]) - DW'(in_r0[i]);
    end
    s2_p <= s1_p;
    s3_p <= s2_p;
    s4_p <= s3_p;
    s5_p <= s4_p;
    s6_p <= s5_p;
    s7_p <= s6_p;
    for (int i = 0; i < NAX; i++) begin
      s2_d[i]  <= s1_d[i];
      s2_e[i]  <= s1_e[i];
      s2_td[i] <= s1_d[i] * $signed({1'b0, box_recip[i]});
      s2_te[i] <= s1_e[i] * $signed({1'b0, box_recip[i]});
      s3_d[i]  <= s2_d[i];
      s3_e[i]  <= s2_e[i];
      s3_pd[i] <= $signed({1'b0, box_len[i]}) * s2_nd[i];
      s3_pe[i] <= $signed({1'b0, box_len[i]}) * s2_ne[i];
      s4_a[i]  <= sat_coord(SATW'(s3_d[i]) - SATW'(s3_pd[i]));
      s4_b[i]  <= sat_coord(SATW'(s3_e[i]) - SATW'(s3_pe[i]));
      s5_a[i]  <= s4_a[i];
      s5_b[i]  <= s4_b[i];
      s5_ab[i] <= s4_a[i] * s4_b[i];
      s5_bq[i] <= s4_b[i] * s4_b[i];
      s6_a[i]  <= s5_a[i];
      s6_b[i]  <= s5_b[i];
      s7_a[i]  <= s6_a[i];
    end
    s5_xa[0] <= s4_b[1] * s4_a[2];
    s5_xb[0] <= s4_b[2] * s4_a[1];
    s5_xa[1] <= s4_b[2] * s4_a[0];
    s5_xb[1] <= s4_b[0] * s4_a[2];
    s5_xa[2] <= s4_b[0] * s4_a[1];
    s5_xb[2] <= s4_b[1] * s4_a[0];
    s5_bzero <= (s4_b[0] == '0) && (s4_b[1] == '0) && (s4_b[2] == '0);
    s6_dot <= DOTW'(s5_ab[0]) + DOTW'(s5_ab[1]) + DOTW'(s5_ab[2]);
    s6_bb  <= $unsigned(s5_bq[0]) + $unsigned(s5_bq[1]) + $unsigned(s5_bq[2]);
    priority if (s5_bzero) begin
      s6_st <= ST_ZERO_BASE;
    end else if (s5_xa[0] == s5_xb[0] && s5_xa[1] == s5_xb[1] && s5_xa[2] == s5_xb[2]) begin
      s6_st <= ST_ON_LINE;
    end else begin
      s6_st <= ST_OK;
    end
  end

  always_comb begin
    s6_abs = s6_dot[DOTW-1] ? DOTW'(-s6_dot) : DOTW'(s6_dot);
    for (int i = 0; i < NAX; i++) begin
      s6_m[i] = s6_b[i][CW-1] ? CW'(-s6_b[i]) : CW'(s6_b[i]);
    end
  end

  always_ff @(posedge clk) begin
    s7_bb <= s6_bb;
    s7_st <= s6_st;
    for (int i = 0; i < NAX; i++) begin
      s7_lo[i]  <= s6_m[i] * s6_abs[CW-1:0];
      s7_hp[i]  <= s6_m[i] * s6_abs[PW-1:CW];
      s7_neg[i] <= s6_b[i][CW-1] ^ s6_dot[DOTW-1];
    end
  end

  always_comb begin
    c8.r0  = s7_p.r0;
    c8.r1  = s7_p.r1;
    c8.s   = s7_p.s;
    c8.st  = s7_st;
    c8.bb  = s7_bb;
    c8.neg = s7_neg;
    for (int i = 0; i < NAX; i++) begin
      c8.a[i] = s7_a[i];
      num8[i] = NUMW'(s7_lo[i]) + (NUMW'(s7_hp[i]) << CW);
    end
  end

  always_comb begin
    logic [PW:0] rem2;
    logic ge;
    for (int k = 0; k < QW; k++) begin
      for (int i = 0; i < NAX; i++) begin
        rem2 = {dv_rem[k][i], dv_qn[k][i][QW-1]};
        ge = rem2 >= {1'b0, dv_c[k].bb};
        dn_rem[k][i] = ge ? PW'(rem2 - {1'b0, dv_c[k].bb}) : PW'(rem2);
        dn_qn[k][i] = {dv_qn[k][i][QW-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    dv_c[0] <= c8;
    for (int i = 0; i < NAX; i++) begin
      dv_rem[0][i] <= PW'(num8[i][NUMW-1:QW]);
      dv_qn[0][i]  <= num8[i][QW-1:0];
    end
    for (int k = 0; k < QW; k++) begin
      dv_c[k+1] <= dv_c[k];
      for (int i = 0; i < NAX; i++) begin
        dv_rem[k+1][i] <= dn_rem[k][i];
        dv_qn[k+1][i]  <= dn_qn[k][i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NAX; i++) begin
      r_mag[i] = MW'(dv_qn[QW][i])
               + MW'({dv_rem[QW][i], 1'b0} >= {1'b0, dv_c[QW].bb});
      r_pv[i] = dv_c[QW].neg[i] ? -$signed({1'b0, r_mag[i]}) : $signed({1'b0, r_mag[i]});
    end
  end

  always_ff @(posedge clk) begin
    r_c <= dv_c[QW];
    for (int i = 0; i < NAX; i++) begin
      r_q[i]    <= QSW'($signed(dv_c[QW].a[i])) - QSW'(r_pv[i]);
      r_base[i] <= QSW'($signed(dv_c[QW].r0[i])) + QSW'(r_pv[i]);
    end
  end

  always_comb begin
    for (int i = 0; i < NAX; i++) begin
      q_abs[i] = r_q[i][QSW-1] ? QSW'(-r_q[i]) : QSW'(r_q[i]);
    end
  end

  always_ff @(posedge clk) begin
    q_c <= r_c;
    for (int i = 0; i < NAX; i++) begin
      q_sq[i]   <= PW'(q_abs[i][QW-1:0] * q_abs[i][QW-1:0]);
      q_sp[i]   <= $signed(r_c.s) * r_q[i];
      q_base[i] <= r_base[i];
    end
  end

  always_comb begin
    a_sum = (PW+2)'(q_sq[0]) + (PW+2)'(q_sq[1]) + (PW+2)'(q_sq[2]);
    a_qq  = (a_sum[PW+1:PW] != 2'b00) ? {PW{1'b1}} : a_sum[PW-1:0];
    a_c.s  = q_c.s;
    a_c.st = q_c.st;
    for (int i = 0; i < NAX; i++) begin
      if (q_c.st == ST_OK) begin
        a_c.apex[i] = sat_coord(SATW'(q_base[i]) + ((SATW'(q_sp[i]) + HALF_F) >>> FB));
      end else begin
        a_c.apex[i] = q_c.r1[i];
      end
    end
  end

  always_comb begin
    logic [SRW+1:0] remx;
    logic [SRW+1:0] trial;
    for (int k = 0; k < SQS; k++) begin
      remx  = {sq_rem[k], sq_x[k][PW-1:PW-2]};
      trial = {2'b00, sq_root[k], 2'b01};
      if (remx >= trial) begin
        sn_rem[k]  = SRW'(remx - trial);
        sn_root[k] = {sq_root[k][SQW-2:0], 1'b1};
      end else begin
        sn_rem[k]  = SRW'(remx);
        sn_root[k] = {sq_root[k][SQW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    sq_c[0]    <= a_c;
    sq_x[0]    <= a_qq;
    sq_rem[0]  <= '0;
    sq_root[0] <= '0;
    for (int k = 0; k < SQS; k++) begin
      sq_c[k+1]    <= sq_c[k];
      sq_x[k+1]    <= sq_x[k] << 2;
      sq_rem[k+1]  <= sn_rem[k];
      sq_root[k+1] <= sn_root[k];
    end
  end

  assign h_root = HW'(sq_root[SQS]) + HW'(sq_rem[SQS] > SRW'(sq_root[SQS]));

  always_ff @(posedge clk) begin
    h_c    <= sq_c[SQS];
    h_prod <= $signed(sq_c[SQS].s) * $signed({1'b0, h_root});
    new_apex_x <= h_c.apex[0];
    new_apex_y <= h_c.apex[1];
    new_apex_z <= h_c.apex[2];
    out_st     <= h_c.st;
    if (h_c.st == ST_OK) begin
      scaled_height <= sat_coord((SATW'(h_prod) + HALF_F) >>> FB);
    end else begin
      scaled_height <= '0;
    end
  end

  `THS_ASSERT_IMPLY(a_zero_base_bb, s6_valid, (s6_st == ST_ZERO_BASE) == (s6_bb == '0))
  `THS_ASSERT_IMPLY(a_div_rem, dv_valid[QW] && dv_c[QW].st == ST_OK, dv_rem[QW][0] < dv_c[QW].bb)
  `THS_ASSERT_IMPLY(a_sqrt_rem, sq_valid[SQS], sq_rem[SQS] <= {1'b0, sq_root[SQS], 1'b0})
  `THS_ASSERT_NEXT(a_height_zero, h_valid && h_c.st != ST_OK, done && scaled_height == '0)

endmodule
